// ===== rtl/core/lds_pkg.sv =====
// Shared constants and types for the largest divisible subset unit.
// No dependencies.
package lds_pkg;

  // Default number of stored values.
  localparam int MAX_ITEMS_DEF = 64;

  // Field widths of the stream payloads.
  localparam int VAL_W  = 31;
  localparam int SIZE_W = 7;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  // Bit counter width of the restoring remainder unit.
  localparam int DCNT_W = 5;

  typedef logic [VAL_W-1:0] val_t;

endpackage : lds_pkg

// ===== rtl/core/largest_divisible_subset_unit.sv =====
// Largest divisible subset engine: load, sort, chain search, trace and emit.
// Depends on lds_pkg.
//
// Usage:
//   The input stream carries one positive value per transfer in in_tdata;
//   in_tlast marks the last value of a set. Up to MAX_ITEMS values are kept,
//   later ones are dropped and reported through the overflow bit.
//   After the last transfer the block stops taking input, sorts the values
//   with an insertion sort in the value memory, then runs the chain search:
//   every pair (j, i) with j < i that could lengthen the chain at i takes two
//   reads and a bitwise restoring remainder step, other pairs only the reads.
//   The chain is traced back through the link memory and its members leave
//   on the output stream in ascending order, with receiver stall honoured;
//   out_tlast flags the last member.
//   A stalled output simply holds the current member; nothing is lost.
//   Reset empties the set; the memories need no clearing since only
//   written entries are ever read.
module largest_divisible_subset_unit #(
  parameter int MAX_ITEMS = lds_pkg::MAX_ITEMS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: value [30:0], zero [31]
  input  logic [lds_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                             in_tlast,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // out_tdata: member [30:0], subset_size [37:31], overflow [38], zero [39]
  output logic [lds_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                             out_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready
);
  import lds_pkg::*;

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);

  typedef enum logic [17:0] {
    ST_LOAD  = 18'h00001,
    ST_S_RDK = 18'h00002,
    ST_S_KEY = 18'h00004,
    ST_S_RDC = 18'h00008,
    ST_S_CMP = 18'h00010,
    ST_S_PUT = 18'h00020,
    ST_D_RDI = 18'h00040,
    ST_D_VI  = 18'h00080,
    ST_D_RDJ = 18'h00100,
    ST_D_J   = 18'h00200,
    ST_D_DIV = 18'h00400,
    ST_D_WR  = 18'h00800,
    ST_T_RD  = 18'h01000,
    ST_T_NX  = 18'h02000,
    ST_E_RD  = 18'h04000,
    ST_E_LV  = 18'h08000,
    ST_E_CAP = 18'h10000,
    ST_E_OUT = 18'h20000
  } state_t;

  // Value memory and link memory (chain length and predecessor fields).
  val_t          val_mem  [MAX_ITEMS];
  logic [CW-1:0] len_mem  [MAX_ITEMS];
  logic [AW-1:0] pred_mem [MAX_ITEMS];

  logic          vm_we;
  logic [AW-1:0] vm_waddr, vm_raddr;
  val_t          vm_wdata, vm_rdata;
  logic          len_we, pred_we;
  logic [AW-1:0] lm_waddr, lm_raddr;
  logic [CW-1:0] len_wdata, len_rdata;
  logic [AW-1:0] pred_wdata, pred_rdata;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          drop_r, drop_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  val_t          key_r, key_nxt, vi_r, vi_nxt, vj_r, vj_nxt;
  val_t          rem_r, rem_nxt, member_r, member_nxt;
  logic [CW-1:0] lj_r, lj_nxt, len_i_r, len_i_nxt, best_len_r, best_len_nxt;
  logic [AW-1:0] pred_i_r, pred_i_nxt, best_idx_r, best_idx_nxt, idx_r, idx_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;

  logic [CW:0]   i_inc, j_inc, k_inc, lj_inc, cnt_inc;
  logic [CW-1:0] jm1, km1;
  logic [VAL_W:0] rem_sh, rem_sub;
  val_t          rem_step;

  assign i_inc   = {1'b0, i_r} + 1'b1;
  assign j_inc   = {1'b0, j_r} + 1'b1;
  assign k_inc   = {1'b0, k_r} + 1'b1;
  assign lj_inc  = {1'b0, lj_r} + 1'b1;
  assign cnt_inc = {1'b0, cnt_r} + 1'b1;
  assign jm1     = j_r - 1'b1;
  assign km1     = k_r - 1'b1;

  // One bit of the restoring remainder of vi by vj.
  assign rem_sh   = {rem_r, vi_r[dcnt_r]};
  assign rem_sub  = rem_sh - {1'b0, vj_r};
  assign rem_step = (rem_sh >= {1'b0, vj_r}) ? rem_sub[VAL_W-1:0] : rem_sh[VAL_W-1:0];

  // Memory ports.
  always_ff @(posedge clk) begin
    if (vm_we) begin
      val_mem[vm_waddr] <= vm_wdata;
    end
    vm_rdata <= val_mem[vm_raddr];
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[lm_waddr] <= len_wdata;
    end
    if (pred_we) begin
      pred_mem[lm_waddr] <= pred_wdata;
    end
    len_rdata  <= len_mem[lm_raddr];
    pred_rdata <= pred_mem[lm_raddr];
  end

  assign in_tready  = (state_r == ST_LOAD);
  assign out_tvalid = (state_r == ST_E_OUT);
  assign out_tlast  = (k_inc == {1'b0, best_len_r});
  assign out_tdata  = {1'b0, drop_r, SIZE_W'(best_len_r), member_r};

  // Sequencer: next state, counters and memory accesses.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    drop_nxt = drop_r;
    i_nxt = i_r;
    j_nxt = j_r;
    k_nxt = k_r;
    key_nxt = key_r;
    vi_nxt = vi_r;
    vj_nxt = vj_r;
    rem_nxt = rem_r;
    member_nxt = member_r;
    lj_nxt = lj_r;
    len_i_nxt = len_i_r;
    best_len_nxt = best_len_r;
    pred_i_nxt = pred_i_r;
    best_idx_nxt = best_idx_r;
    idx_nxt = idx_r;
    dcnt_nxt = dcnt_r;
    vm_we = 1'b0;
    vm_waddr = '0;
    vm_wdata = key_r;
    vm_raddr = '0;
    len_we = 1'b0;
    pred_we = 1'b0;
    lm_waddr = '0;
    lm_raddr = '0;
    len_wdata = len_i_r;
    pred_wdata = pred_i_r;

    case (state_r)
      ST_LOAD: begin
        if (in_tvalid) begin
          if (cnt_r != CW'(MAX_ITEMS)) begin
            vm_we = 1'b1;
            vm_waddr = cnt_r[AW-1:0];
            vm_wdata = in_tdata[VAL_W-1:0];
            cnt_nxt = cnt_inc[CW-1:0];
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_tlast) begin
            best_len_nxt = '0;
            best_idx_nxt = '0;
            if (cnt_nxt >= CW'(2)) begin
              i_nxt = CW'(1);
              state_nxt = ST_S_RDK;
            end else begin
              i_nxt = '0;
              state_nxt = ST_D_RDI;
            end
          end
        end
      end
      // Insertion sort.
      ST_S_RDK: begin
        vm_raddr = i_r[AW-1:0];
        state_nxt = ST_S_KEY;
      end
      ST_S_KEY: begin
        key_nxt = vm_rdata;
        j_nxt = i_r;
        state_nxt = ST_S_RDC;
      end
      ST_S_RDC: begin
        vm_raddr = jm1[AW-1:0];
        state_nxt = ST_S_CMP;
      end
      ST_S_CMP: begin
        if (vm_rdata > key_r) begin
          vm_we = 1'b1;
          vm_waddr = j_r[AW-1:0];
          vm_wdata = vm_rdata;
          j_nxt = jm1;
          state_nxt = (j_r == CW'(1)) ? ST_S_PUT : ST_S_RDC;
        end else begin
          state_nxt = ST_S_PUT;
        end
      end
      ST_S_PUT: begin
        vm_we = 1'b1;
        vm_waddr = j_r[AW-1:0];
        i_nxt = i_inc[CW-1:0];
        if (i_inc < {1'b0, cnt_r}) begin
          state_nxt = ST_S_RDK;
        end else begin
          i_nxt = '0;
          state_nxt = ST_D_RDI;
        end
      end
      // Chain search over every earlier value.
      ST_D_RDI: begin
        vm_raddr = i_r[AW-1:0];
        state_nxt = ST_D_VI;
      end
      ST_D_VI: begin
        vi_nxt = vm_rdata;
        len_i_nxt = CW'(1);
        pred_i_nxt = i_r[AW-1:0];
        j_nxt = '0;
        state_nxt = (i_r == '0) ? ST_D_WR : ST_D_RDJ;
      end
      ST_D_RDJ: begin
        vm_raddr = j_r[AW-1:0];
        lm_raddr = j_r[AW-1:0];
        state_nxt = ST_D_J;
      end
      ST_D_J: begin
        vj_nxt = vm_rdata;
        lj_nxt = len_rdata;
        if ((({1'b0, len_rdata} + 1'b1) > {1'b0, len_i_r}) && (vm_rdata != '0)) begin
          rem_nxt = '0;
          dcnt_nxt = DCNT_W'(VAL_W - 1);
          state_nxt = ST_D_DIV;
        end else begin
          j_nxt = j_inc[CW-1:0];
          state_nxt = (j_inc < {1'b0, i_r}) ? ST_D_RDJ : ST_D_WR;
        end
      end
      ST_D_DIV: begin
        rem_nxt = rem_step;
        dcnt_nxt = dcnt_r - 1'b1;
        if (dcnt_r == '0) begin
          if (rem_step == '0) begin
            len_i_nxt = lj_inc[CW-1:0];
            pred_i_nxt = j_r[AW-1:0];
          end
          j_nxt = j_inc[CW-1:0];
          state_nxt = (j_inc < {1'b0, i_r}) ? ST_D_RDJ : ST_D_WR;
        end
      end
      ST_D_WR: begin
        len_we = 1'b1;
        pred_we = 1'b1;
        lm_waddr = i_r[AW-1:0];
        if (len_i_r > best_len_r) begin
          best_len_nxt = len_i_r;
          best_idx_nxt = i_r[AW-1:0];
        end
        i_nxt = i_inc[CW-1:0];
        if (i_inc < {1'b0, cnt_r}) begin
          state_nxt = ST_D_RDI;
        end else begin
          k_nxt = best_len_nxt;
          idx_nxt = best_idx_nxt;
          state_nxt = ST_T_RD;
        end
      end
      // Trace back; member indexes go into the length field by position.
      ST_T_RD: begin
        lm_raddr = idx_r;
        len_we = 1'b1;
        lm_waddr = km1[AW-1:0];
        len_wdata = CW'(idx_r);
        state_nxt = ST_T_NX;
      end
      ST_T_NX: begin
        idx_nxt = pred_rdata;
        k_nxt = km1;
        if (k_r == CW'(1)) begin
          k_nxt = '0;
          state_nxt = ST_E_RD;
        end else begin
          state_nxt = ST_T_RD;
        end
      end
      // Emit members in ascending order.
      ST_E_RD: begin
        lm_raddr = k_r[AW-1:0];
        state_nxt = ST_E_LV;
      end
      ST_E_LV: begin
        vm_raddr = len_rdata[AW-1:0];
        state_nxt = ST_E_CAP;
      end
      ST_E_CAP: begin
        member_nxt = vm_rdata;
        state_nxt = ST_E_OUT;
      end
      ST_E_OUT: begin
        if (out_tready) begin
          if (k_inc == {1'b0, best_len_r}) begin
            cnt_nxt = '0;
            drop_nxt = 1'b0;
            state_nxt = ST_LOAD;
          end else begin
            k_nxt = k_inc[CW-1:0];
            state_nxt = ST_E_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      drop_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      drop_r  <= drop_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    j_r <= j_nxt;
    k_r <= k_nxt;
    key_r <= key_nxt;
    vi_r <= vi_nxt;
    vj_r <= vj_nxt;
    rem_r <= rem_nxt;
    member_r <= member_nxt;
    lj_r <= lj_nxt;
    len_i_r <= len_i_nxt;
    best_len_r <= best_len_nxt;
    pred_i_r <= pred_i_nxt;
    best_idx_r <= best_idx_nxt;
    idx_r <= idx_nxt;
    dcnt_r <= dcnt_nxt;
  end

endmodule : largest_divisible_subset_unit

// ===== tb/testbench.sv =====
// Testbench for the largest divisible subset unit: drives sets of values on the
// input stream and checks every subset member against a built-in predictor.
// Depends on lds_pkg and largest_divisible_subset_unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lds_pkg::*;

  localparam int CAP = MAX_ITEMS_DEF;

  typedef struct packed {
    logic       ovf;
    logic [6:0] size;
    logic       last;
    val_t       member;
  } member_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tlast;
  logic out_tvalid;
  logic out_tready = 1'b0;

  largest_divisible_subset_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tlast(in_tlast), .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast), .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: the set being loaded.
  val_t set_vals[CAP];
  int   set_count = 0;
  logic set_dropped = 1'b0;
  member_t expected_members[$];
  int   error_count = 0;
  bit   idle_enable = 1'b1;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  // Store one value and, on the final one, compute the expected subset.
  task automatic predict_subset(input val_t v, input logic fin);
    val_t s[CAP];
    int len[CAP];
    int prv[CAP];
    val_t chain[CAP];
    int n, best_len, best_idx, idx;
    val_t key;
    member_t m;
    if (set_count < CAP) begin
      set_vals[set_count] = v;
      set_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (!fin) return;
    n = set_count;
    for (int i = 0; i < n; i++) s[i] = set_vals[i];
    // Stable insertion sort.
    for (int i = 1; i < n; i++) begin
      int j;
      key = s[i];
      j = i;
      while (j > 0 && s[j-1] > key) begin
        s[j] = s[j-1];
        j--;
      end
      s[j] = key;
    end
    best_len = 0;
    best_idx = 0;
    for (int i = 0; i < n; i++) begin
      len[i] = 1;
      prv[i] = i;
      for (int j = 0; j < i; j++) begin
        if (s[j] != 0 && (s[i] % s[j]) == 0 && len[j] + 1 > len[i]) begin
          len[i] = len[j] + 1;
          prv[i] = j;
        end
      end
      if (len[i] > best_len) begin
        best_len = len[i];
        best_idx = i;
      end
    end
    idx = best_idx;
    for (int k = best_len; k > 0; k--) begin
      chain[k-1] = s[idx];
      idx = prv[idx];
    end
    for (int k = 0; k < best_len; k++) begin
      m.member = chain[k];
      m.last = (k + 1 == best_len);
      m.size = best_len[6:0];
      m.ovf = set_dropped;
      expected_members.push_back(m);
    end
    set_count = 0;
    set_dropped = 1'b0;
  endtask

  // Send one value, at times with a random gap in front of it. The valid line stays
  // high after a transfer so the next value can follow without a gap.
  task automatic send_value(input val_t v, input logic fin);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tdata <= {1'b0, v};
    in_tlast <= fin;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    predict_subset(v, fin);
  endtask

  // Receiver stall bursts.
  initial begin
    forever begin
      @(posedge clk);
      if (idle_enable && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // Check each member transfer against the oldest expectation.
  always @(posedge clk) begin
    member_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_members.size() == 0) begin
        report_mismatch("unexpected member", out_tdata[30:0], 0);
      end else begin
        w = expected_members.pop_front();
        if (out_tdata[30:0] !== w.member) report_mismatch("member", out_tdata[30:0], w.member);
        if (out_tlast !== w.last) report_mismatch("end_of_subset", out_tlast, w.last);
        if (out_tdata[37:31] !== w.size) report_mismatch("subset_size", out_tdata[37:31], w.size);
        if (out_tdata[38] !== w.ovf) report_mismatch("overflow", out_tdata[38], w.ovf);
      end
    end
  end

  function automatic val_t rand_value();
    case ($urandom_range(0, 4))
      0: return val_t'($urandom_range(1, 12));
      1: return val_t'(1 << $urandom_range(0, 30));
      2: return val_t'(3 << $urandom_range(0, 29));
      3: return val_t'($urandom_range(1, 100));
      default: return val_t'(($urandom() & 32'h7FFF_FFFF) | 32'd1);
    endcase
  endfunction

  task automatic test_extremes();
    send_value(31'h7FFF_FFFF, 1'b1);
    send_value(31'd1, 1'b1);
    send_value(31'd1, 1'b0);
    send_value(31'h4000_0000, 1'b0);
    send_value(31'h7FFF_FFFF, 1'b1);
  endtask

  task automatic test_ties_and_duplicates();
    send_value(31'd6, 1'b0);
    send_value(31'd3, 1'b0);
    send_value(31'd2, 1'b0);
    send_value(31'd12, 1'b0);
    send_value(31'd5, 1'b1);
    send_value(31'd7, 1'b0);
    send_value(31'd7, 1'b0);
    send_value(31'd14, 1'b0);
    send_value(31'd7, 1'b1);
    send_value(31'd9, 1'b0);
    send_value(31'd5, 1'b1);
  endtask

  // Fill past capacity so later items, the final one too, are dropped.
  task automatic test_overflow();
    for (int i = 0; i < CAP + 3; i++)
      send_value(rand_value(), i == CAP + 2);
  endtask

  // Wait for every expected member before the next value goes in.
  task automatic test_drain_pause();
    send_value(31'd4, 1'b0);
    send_value(31'd8, 1'b1);
    in_tvalid <= 1'b0;
    while (expected_members.size() != 0) @(posedge clk);
    send_value(31'd16, 1'b1);
  endtask

  task automatic test_random_sets(input int n_items, input int max_len);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(1, max_len);
      for (int i = 0; i < len; i++) send_value(rand_value(), i == len - 1);
      sent += len;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_ties_and_duplicates();
    test_drain_pause();
    test_overflow();
    test_random_sets(60, 10);
    idle_enable = 1'b0;
    test_random_sets(25, 8);
    in_tvalid <= 1'b0;
    while (expected_members.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (error_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule

// ===== largest_divisible_subset_unit.f =====
rtl/core/lds_pkg.sv
rtl/core/largest_divisible_subset_unit.sv
tb/testbench.sv
